@@ hw/rtl/mtg_pkg.sv @@
// ----------------------------------------------------------------------------
// Multitouch tracker package
// Shared widths, operation and result codes, the CORDIC angle table and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int SLOTS_DEF    = 10;
	localparam int SLOT_W       = 4;
	localparam int KIND_W       = 3;
	localparam int POS_W        = 16;
	localparam int SID_W        = 31;
	localparam int ANG_W        = 16;
	localparam int CNT_W        = 4;
	localparam int LIST_W       = 6;
	localparam int MOVE_W       = 17;
	localparam int GROW_W       = 18;
	localparam int ROOT_W       = 17;
	localparam int CORDIC_STEPS = 15;
	localparam int CORDIC_W     = 28;
	localparam int CORDIC_SCALE = 8;

	// Operation codes of an input item.
	localparam logic [1:0] OP_SET       = 2'd0;
	localparam logic [1:0] OP_ALIVE     = 2'd1;
	localparam logic [1:0] OP_ALIVE_END = 2'd2;
	localparam logic [1:0] OP_FRAME     = 2'd3;

	// Kinds of a result item.
	localparam logic [KIND_W-1:0] KIND_SET_DONE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET_REJ  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_COUNT    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_AGG      = 3'd4;

	// Destinations of the shared divider.
	localparam logic [2:0] DIV_CX  = 3'd0;
	localparam logic [2:0] DIV_CY  = 3'd1;
	localparam logic [2:0] DIV_MX  = 3'd2;
	localparam logic [2:0] DIV_MY  = 3'd3;
	localparam logic [2:0] DIV_ROT = 3'd4;

	// Arctangent of 2^-i in binary angle units.
	function automatic logic [ANG_W-1:0] atan_lut(input logic [3:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			4'd0:    a = 16'd8192;
			4'd1:    a = 16'd4836;
			4'd2:    a = 16'd2555;
			4'd3:    a = 16'd1297;
			4'd4:    a = 16'd651;
			4'd5:    a = 16'd326;
			4'd6:    a = 16'd163;
			4'd7:    a = 16'd81;
			4'd8:    a = 16'd41;
			4'd9:    a = 16'd20;
			4'd10:   a = 16'd10;
			4'd11:   a = 16'd5;
			4'd12:   a = 16'd3;
			4'd13:   a = 16'd1;
			4'd14:   a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

	typedef struct packed {
		logic       capture;
		logic       idx_clr;
		logic       idx_inc;
		logic       acc_clr;
		logic       set_step;
		logic       set_commit;
		logic       alive_mark;
		logic       emit_count;
		logic       remove_step;
		logic       alive_clear;
		logic       agg_step;
		logic       div_start;
		logic [2:0] div_sel;
		logic       sq_start;
		logic       sq_prev;
		logic       cor_start;
		logic       cor_prev;
		logic       a1_keep;
		logic       rot_acc;
		logic       emit_agg;
	} mtg_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic act_idx;
		logic pend_idx;
		logic out_full;
		logic cnt_zero;
		logic div_done;
		logic sq_done;
		logic cor_done;
	} mtg_sts_t;

endpackage

@@ hw/rtl/mtg_cordic.sv @@
// ----------------------------------------------------------------------------
// CORDIC vectoring unit
// Returns the binary angle of a signed vector, one rotation step per cycle.
// ----------------------------------------------------------------------------
module mtg_cordic import mtg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [POS_W:0]    vec_x,
	input  logic signed [POS_W:0]    vec_y,
	output logic                     done,
	output logic [ANG_W-1:0]         angle
);

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic [ANG_W-1:0]           z_q;
	logic [3:0]                 step_q;
	logic                       busy_q, done_q;
	logic                       neg;
	logic signed [POS_W:0]      ax, ay;
	logic signed [CORDIC_W-1:0] xs, ys;

	// Fold the left half plane onto the right one.
	always_comb begin
		neg = vec_x < 0;
		ax  = neg ? -vec_x : vec_x;
		ay  = neg ? -vec_y : vec_y;
		xs  = x_q >>> step_q;
		ys  = y_q >>> step_q;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				if (vec_x == 0 && vec_y == 0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Rotation datapath; shifts round toward minus infinity.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_W'(ax) <<< CORDIC_SCALE;
			y_q <= CORDIC_W'(ay) <<< CORDIC_SCALE;
			z_q <= neg ? 16'd32768 : 16'd0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_lut(step_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_lut(step_q);
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

@@ hw/rtl/mtg_datapath.sv @@
// ----------------------------------------------------------------------------
// Multitouch tracker datapath
// Slot table, frame accumulators, divider, square root, angle unit and the
// output register.
// ----------------------------------------------------------------------------
module mtg_datapath import mtg_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mtg_cmd_t                  cmd,
	output mtg_sts_t                  sts,
	input  logic [SID_W-1:0]          session_id,
	input  logic [POS_W-1:0]          pos_x,
	input  logic [POS_W-1:0]          pos_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [KIND_W-1:0]         kind,
	output logic [SLOT_W-1:0]         slot,
	output logic [POS_W-1:0]          out_x,
	output logic [POS_W-1:0]          out_y,
	output logic signed [MOVE_W-1:0]  move_x,
	output logic signed [MOVE_W-1:0]  move_y,
	output logic signed [GROW_W-1:0]  growth,
	output logic signed [ANG_W-1:0]   rotation,
	output logic [CNT_W-1:0]          contact_count,
	output logic                      last
);

	localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int DW  = POS_W + CW;
	localparam int DSW = $clog2(DW + 1);

	// Captured input item.
	logic [SID_W-1:0] sid_q;
	logic [POS_W-1:0] px_q, py_q;

	// Slot table.
	logic [SLOTS-1:0]     active_q, seen_q;
	logic [SID_W-1:0]     sess_q [SLOTS];
	logic [2*POS_W-1:0]   cur_q  [SLOTS];
	logic [2*POS_W-1:0]   prev_q [SLOTS];
	logic [LIST_W-1:0]    listed_q;

	logic [IW-1:0] idx_q, hit_idx_q, spare_idx_q, tgt;
	logic          hit_q, spare_q;

	// Frame accumulators.
	logic [CW-1:0]          cnt_q;
	logic [DW-1:0]          sx_q, sy_q;
	logic signed [DW:0]     dx_q, dy_q, rsum_q;
	logic [POS_W-1:0]       cminx_q, cmaxx_q, cminy_q, cmaxy_q;
	logic [POS_W-1:0]       pminx_q, pmaxx_q, pminy_q, pmaxy_q;
	logic [POS_W-1:0]       cx_q, cy_q;
	logic signed [MOVE_W-1:0] mx_q, my_q;
	logic signed [ANG_W-1:0]  rot_q;
	logic [ANG_W-1:0]       a1_q;

	// Divider.
	logic              div_busy_q, div_done_q;
	logic [DSW-1:0]    div_step_q;
	logic [CW-1:0]     div_rem_q;
	logic [DW-1:0]     div_quo_q;
	logic              div_neg_q;
	logic [2:0]        div_dst_q;
	logic [CW:0]       div_sh;
	logic [CW-1:0]     div_rem_nx;
	logic [DW-1:0]     div_quo_nx;
	logic signed [DW:0] div_res;
	logic signed [DW:0] div_src;
	logic              div_src_neg;

	// Square root.
	logic [4:0]               sq_step_q;
	logic [2*POS_W:0]         sq_v_q;
	logic [ROOT_W-1:0]        sq_r_q, sq_trial, sq_r_nx, sq_a;
	logic                     sq_prev_q, sq_done_q, sq_sel;
	logic [2*ROOT_W-1:0]      sq_prod;
	logic [POS_W-1:0]         sq_w, sq_h;
	logic signed [GROW_W-1:0] gr_q;

	// Angle unit.
	logic                   cor_done;
	logic [ANG_W-1:0]       cor_angle;
	logic signed [POS_W:0]  cor_x, cor_y;
	logic [ANG_W-1:0]       rot_d;

	// Output register and the fields loaded into it.
	logic                     out_valid_q;
	logic                     emit_any;
	logic [KIND_W-1:0]        kind_d;
	logic [SLOT_W-1:0]        slot_d;
	logic [POS_W-1:0]         ox_d, oy_d;
	logic signed [MOVE_W-1:0] mx_d, my_d;
	logic signed [GROW_W-1:0] gr_d;
	logic signed [ANG_W-1:0]  rotation_d;
	logic [CNT_W-1:0]         cnt_d;
	logic                     last_d;

	logic [POS_W-1:0]      x1, y1, x0, y0;
	logic signed [POS_W:0] ddx, ddy;
	logic [SLOTS-1:0]      pend;
	logic                  pend_after;

	// Fields of the slot under the scan index.
	always_comb begin
		x1  = cur_q[idx_q][POS_W-1:0];
		y1  = cur_q[idx_q][2*POS_W-1:POS_W];
		x0  = prev_q[idx_q][POS_W-1:0];
		y0  = prev_q[idx_q][2*POS_W-1:POS_W];
		ddx = $signed({1'b0, x1}) - $signed({1'b0, x0});
		ddy = $signed({1'b0, y1}) - $signed({1'b0, y0});
		tgt = hit_q ? hit_idx_q : spare_idx_q;
	end

	// Slots to free at alive end, and whether one lies above the index.
	always_comb begin
		pend       = active_q & ~seen_q;
		pend_after = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (IW'(j) > idx_q && pend[j]) begin
				pend_after = 1'b1;
			end
		end
	end

	// Input capture and scan index.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sid_q <= session_id;
			px_q  <= pos_x;
			py_q  <= pos_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Slot flags and the listed id count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			seen_q   <= '0;
			listed_q <= '0;
		end else begin
			if (cmd.set_commit && !hit_q && spare_q) begin
				active_q[tgt] <= 1'b1;
				seen_q[tgt]   <= 1'b0;
			end
			if (cmd.alive_mark) begin
				for (int j = 0; j < SLOTS; j++) begin
					if (active_q[j] && sess_q[j] == sid_q) begin
						seen_q[j] <= 1'b1;
					end
				end
				if (listed_q != {LIST_W{1'b1}}) begin
					listed_q <= listed_q + 1'b1;
				end
			end
			if (cmd.remove_step) begin
				active_q[idx_q] <= 1'b0;
			end
			if (cmd.alive_clear) begin
				seen_q   <= '0;
				listed_q <= '0;
			end
		end
	end

	// Slot contents.
	always_ff @(posedge clk) begin
		if (cmd.set_commit) begin
			if (hit_q) begin
				prev_q[tgt] <= cur_q[tgt];
				cur_q[tgt]  <= {py_q, px_q};
			end else if (spare_q) begin
				sess_q[tgt] <= sid_q;
				cur_q[tgt]  <= {py_q, px_q};
				prev_q[tgt] <= {py_q, px_q};
			end
		end
	end

	// Set lookup: first matching slot, else highest free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			spare_q <= 1'b0;
		end else if (cmd.acc_clr) begin
			hit_q   <= 1'b0;
			spare_q <= 1'b0;
		end else if (cmd.set_step && !hit_q) begin
			if (active_q[idx_q] && sess_q[idx_q] == sid_q) begin
				hit_q <= 1'b1;
			end else if (!active_q[idx_q]) begin
				spare_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_step && !hit_q) begin
			if (active_q[idx_q] && sess_q[idx_q] == sid_q) begin
				hit_idx_q <= idx_q;
			end else if (!active_q[idx_q]) begin
				spare_idx_q <= idx_q;
			end
		end
	end

	// Frame sums, extents and rotation sum.
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			cnt_q   <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			rsum_q  <= '0;
			cminx_q <= '1;
			cminy_q <= '1;
			pminx_q <= '1;
			pminy_q <= '1;
			cmaxx_q <= '0;
			cmaxy_q <= '0;
			pmaxx_q <= '0;
			pmaxy_q <= '0;
		end else begin
			if (cmd.agg_step && active_q[idx_q]) begin
				cnt_q <= cnt_q + 1'b1;
				sx_q  <= sx_q + DW'(x1);
				sy_q  <= sy_q + DW'(y1);
				dx_q  <= dx_q + (DW+1)'(ddx);
				dy_q  <= dy_q + (DW+1)'(ddy);
				if (x1 < cminx_q) cminx_q <= x1;
				if (x1 > cmaxx_q) cmaxx_q <= x1;
				if (y1 < cminy_q) cminy_q <= y1;
				if (y1 > cmaxy_q) cmaxy_q <= y1;
				if (x0 < pminx_q) pminx_q <= x0;
				if (x0 > pmaxx_q) pmaxx_q <= x0;
				if (y0 < pminy_q) pminy_q <= y0;
				if (y0 > pmaxy_q) pmaxy_q <= y0;
			end
			if (cmd.rot_acc) begin
				rsum_q <= rsum_q + (DW+1)'($signed(rot_d));
			end
		end
	end

	// Divider operand selection and one restoring step.
	always_comb begin
		case (cmd.div_sel)
			DIV_CX:  div_src = $signed({1'b0, sx_q});
			DIV_CY:  div_src = $signed({1'b0, sy_q});
			DIV_MX:  div_src = dx_q;
			DIV_MY:  div_src = dy_q;
			default: div_src = rsum_q;
		endcase
		div_src_neg = div_src < 0;
		div_sh      = {div_rem_q, div_quo_q[DW-1]};
		if (div_sh >= {1'b0, cnt_q}) begin
			div_rem_nx = CW'(div_sh - {1'b0, cnt_q});
			div_quo_nx = {div_quo_q[DW-2:0], 1'b1};
		end else begin
			div_rem_nx = div_sh[CW-1:0];
			div_quo_nx = {div_quo_q[DW-2:0], 1'b0};
		end
		div_res = div_neg_q ? -$signed({1'b0, div_quo_nx}) : $signed({1'b0, div_quo_nx});
		rot_d   = cor_angle - a1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_step_q <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_step_q <= '0;
			end else if (div_busy_q) begin
				div_step_q <= div_step_q + 1'b1;
				if (div_step_q == DSW'(DW - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= div_src_neg ? DW'(-div_src) : DW'(div_src);
			div_neg_q <= div_src_neg;
			div_dst_q <= cmd.div_sel;
		end else if (div_busy_q) begin
			div_rem_q <= div_rem_nx;
			div_quo_q <= div_quo_nx;
			if (div_step_q == DSW'(DW - 1)) begin
				case (div_dst_q)
					DIV_CX:  cx_q  <= div_res[POS_W-1:0];
					DIV_CY:  cy_q  <= div_res[POS_W-1:0];
					DIV_MX:  mx_q  <= div_res[MOVE_W-1:0];
					DIV_MY:  my_q  <= div_res[MOVE_W-1:0];
					default: rot_q <= div_res[ANG_W-1:0];
				endcase
			end
		end
	end

	// Square root of the squared diagonal, one result bit per cycle.
	always_comb begin
		sq_sel   = cmd.sq_start ? cmd.sq_prev : sq_prev_q;
		sq_w     = sq_sel ? pmaxx_q - pminx_q : cmaxx_q - cminx_q;
		sq_h     = sq_sel ? pmaxy_q - pminy_q : cmaxy_q - cminy_q;
		sq_trial = sq_r_q | (ROOT_W'(1) << (sq_step_q - 5'd1));
		if (cmd.sq_start) begin
			sq_a = ROOT_W'(sq_w);
		end else if (sq_step_q == 5'(ROOT_W + 1)) begin
			sq_a = ROOT_W'(sq_h);
		end else begin
			sq_a = sq_trial;
		end
		sq_prod = sq_a * sq_a;
		sq_r_nx = (sq_prod <= (2*ROOT_W)'(sq_v_q)) ? sq_trial : sq_r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_step_q <= '0;
			sq_done_q <= 1'b0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd.sq_start) begin
				sq_step_q <= 5'(ROOT_W + 1);
			end else if (sq_step_q != '0) begin
				sq_step_q <= sq_step_q - 5'd1;
				if (sq_step_q == 5'd1) begin
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_start) begin
			sq_v_q    <= (2*POS_W+1)'(sq_prod);
			sq_r_q    <= '0;
			sq_prev_q <= cmd.sq_prev;
		end else if (sq_step_q == 5'(ROOT_W + 1)) begin
			sq_v_q <= sq_v_q + (2*POS_W+1)'(sq_prod);
		end else if (sq_step_q != '0) begin
			sq_r_q <= sq_r_nx;
			if (sq_step_q == 5'd1) begin
				if (sq_prev_q) begin
					gr_q <= gr_q - $signed({1'b0, sq_r_nx});
				end else begin
					gr_q <= $signed({1'b0, sq_r_nx});
				end
			end
		end
	end

	// Vector from the centroid to the previous or current position.
	always_comb begin
		if (cmd.cor_prev) begin
			cor_x = $signed({1'b0, x0}) - $signed({1'b0, cx_q});
			cor_y = $signed({1'b0, y0}) - $signed({1'b0, cy_q});
		end else begin
			cor_x = $signed({1'b0, x1}) - $signed({1'b0, cx_q});
			cor_y = $signed({1'b0, y1}) - $signed({1'b0, cy_q});
		end
	end

	mtg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cor_start),
		.vec_x  (cor_x),
		.vec_y  (cor_y),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	always_ff @(posedge clk) begin
		if (cmd.a1_keep) begin
			a1_q <= cor_angle;
		end
	end

	// Fields of the next result item.
	always_comb begin
		emit_any   = cmd.set_commit || cmd.emit_count || cmd.remove_step || cmd.emit_agg;
		kind_d     = KIND_COUNT;
		slot_d     = '0;
		ox_d       = '0;
		oy_d       = '0;
		mx_d       = '0;
		my_d       = '0;
		gr_d       = '0;
		rotation_d = '0;
		cnt_d      = '0;
		last_d     = 1'b1;
		if (cmd.set_commit) begin
			if (hit_q || spare_q) begin
				kind_d = KIND_SET_DONE;
				slot_d = SLOT_W'(tgt);
				ox_d   = px_q;
				oy_d   = py_q;
			end else begin
				kind_d = KIND_SET_REJ;
			end
		end else if (cmd.emit_count) begin
			cnt_d  = (listed_q > LIST_W'(15)) ? 4'd15 : listed_q[CNT_W-1:0];
			last_d = pend == '0;
		end else if (cmd.remove_step) begin
			kind_d = KIND_REMOVED;
			slot_d = SLOT_W'(idx_q);
			last_d = !pend_after;
		end else if (cmd.emit_agg) begin
			kind_d     = KIND_AGG;
			ox_d       = cx_q;
			oy_d       = cy_q;
			mx_d       = mx_q;
			my_d       = my_q;
			gr_d       = gr_q;
			rotation_d = rot_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			kind          <= kind_d;
			slot          <= slot_d;
			out_x         <= ox_d;
			out_y         <= oy_d;
			move_x        <= mx_d;
			move_y        <= my_d;
			growth        <= gr_d;
			rotation      <= rotation_d;
			contact_count <= cnt_d;
			last          <= last_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.idx_last = idx_q == IW'(SLOTS - 1);
		sts.act_idx  = active_q[idx_q];
		sts.pend_idx = pend[idx_q];
		sts.out_full = out_valid_q;
		sts.cnt_zero = cnt_q == '0;
		sts.div_done = div_done_q;
		sts.sq_done  = sq_done_q;
		sts.cor_done = cor_done;
	end

endmodule

@@ hw/rtl/mtg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Multitouch tracker controller
// Sequences slot scans, the divider, square root and angle unit per item.
// ----------------------------------------------------------------------------
module mtg_ctrl import mtg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  mtg_sts_t   sts,
	output mtg_cmd_t   cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SET    = 5'd1;
	localparam logic [4:0] S_SET_WR = 5'd2;
	localparam logic [4:0] S_ALIVE  = 5'd3;
	localparam logic [4:0] S_CNT    = 5'd4;
	localparam logic [4:0] S_REM    = 5'd5;
	localparam logic [4:0] S_ACLR   = 5'd6;
	localparam logic [4:0] S_AGG    = 5'd7;
	localparam logic [4:0] S_CHK    = 5'd8;
	localparam logic [4:0] S_DCX    = 5'd9;
	localparam logic [4:0] S_DCY    = 5'd10;
	localparam logic [4:0] S_DMX    = 5'd11;
	localparam logic [4:0] S_DMY    = 5'd12;
	localparam logic [4:0] S_SQC    = 5'd13;
	localparam logic [4:0] S_SQP    = 5'd14;
	localparam logic [4:0] S_ROT    = 5'd15;
	localparam logic [4:0] S_C0     = 5'd16;
	localparam logic [4:0] S_C1     = 5'd17;
	localparam logic [4:0] S_DR     = 5'd18;
	localparam logic [4:0] S_WR     = 5'd19;
	localparam logic [4:0] S_EMIT   = 5'd20;

	logic [4:0] state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = state_q == S_IDLE;

	// Next state and commands.
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					case (operation)
						OP_SET:       state_nx = S_SET;
						OP_ALIVE:     state_nx = S_ALIVE;
						OP_ALIVE_END: state_nx = S_CNT;
						default:      state_nx = S_AGG;
					endcase
				end
			end
			S_SET: begin
				cmd.set_step = 1'b1;
				if (sts.idx_last) begin
					state_nx = S_SET_WR;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SET_WR: begin
				if (!sts.out_full) begin
					cmd.set_commit = 1'b1;
					state_nx       = S_IDLE;
				end
			end
			S_ALIVE: begin
				cmd.alive_mark = 1'b1;
				state_nx       = S_IDLE;
			end
			S_CNT: begin
				if (!sts.out_full) begin
					cmd.emit_count = 1'b1;
					state_nx       = S_REM;
				end
			end
			S_REM: begin
				if (!sts.pend_idx || !sts.out_full) begin
					cmd.remove_step = sts.pend_idx;
					if (sts.idx_last) begin
						state_nx = S_ACLR;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_ACLR: begin
				cmd.alive_clear = 1'b1;
				state_nx        = S_IDLE;
			end
			S_AGG: begin
				cmd.agg_step = 1'b1;
				if (sts.idx_last) begin
					state_nx = S_CHK;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_CHK: begin
				if (sts.cnt_zero) begin
					state_nx = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_CX;
					state_nx      = S_DCX;
				end
			end
			S_DCX: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_CY;
					state_nx      = S_DCY;
				end
			end
			S_DCY: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_MX;
					state_nx      = S_DMX;
				end
			end
			S_DMX: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_MY;
					state_nx      = S_DMY;
				end
			end
			S_DMY: begin
				if (sts.div_done) begin
					cmd.sq_start = 1'b1;
					state_nx     = S_SQC;
				end
			end
			S_SQC: begin
				if (sts.sq_done) begin
					cmd.sq_start = 1'b1;
					cmd.sq_prev  = 1'b1;
					state_nx     = S_SQP;
				end
			end
			S_SQP: begin
				if (sts.sq_done) begin
					cmd.idx_clr = 1'b1;
					state_nx    = S_ROT;
				end
			end
			S_ROT: begin
				if (sts.act_idx) begin
					cmd.cor_start = 1'b1;
					cmd.cor_prev  = 1'b1;
					state_nx      = S_C0;
				end else if (sts.idx_last) begin
					state_nx = S_DR;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_C0: begin
				if (sts.cor_done) begin
					cmd.a1_keep   = 1'b1;
					cmd.cor_start = 1'b1;
					state_nx      = S_C1;
				end
			end
			S_C1: begin
				if (sts.cor_done) begin
					cmd.rot_acc = 1'b1;
					if (sts.idx_last) begin
						state_nx = S_DR;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nx    = S_ROT;
					end
				end
			end
			S_DR: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_ROT;
				state_nx      = S_WR;
			end
			S_WR: begin
				if (sts.div_done) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.out_full) begin
					cmd.emit_agg = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/multitouch_tracker_gesture_top.sv @@
// A set and an alive end each scan all slots, and each waits while the output register is full.
// A frame end scans the slots, then runs the serial divider and root, and the CORDIC unit
// for each active slot.
// One item is worked at a time; a new item is taken while a result waits in the output.
// Reset clears the slot flags, the listed count and all control; slot ids and
// positions are undefined until a slot is claimed.
// ----------------------------------------------------------------------------
// Multitouch tracker top level
// Contact slot table with alive handling and frame gesture aggregates.
// ----------------------------------------------------------------------------
module multitouch_tracker_gesture_top import mtg_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                operation,
	input  logic [SID_W-1:0]          session_id,
	input  logic [POS_W-1:0]          pos_x,
	input  logic [POS_W-1:0]          pos_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [KIND_W-1:0]         kind,
	output logic [SLOT_W-1:0]         slot,
	output logic [POS_W-1:0]          out_x,
	output logic [POS_W-1:0]          out_y,
	output logic signed [MOVE_W-1:0]  move_x,
	output logic signed [MOVE_W-1:0]  move_y,
	output logic signed [GROW_W-1:0]  growth,
	output logic signed [ANG_W-1:0]   rotation,
	output logic [CNT_W-1:0]          contact_count,
	output logic                      last
);

	mtg_cmd_t cmd;
	mtg_sts_t sts;

	mtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	mtg_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.session_id    (session_id),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.slot          (slot),
		.out_x         (out_x),
		.out_y         (out_y),
		.move_x        (move_x),
		.move_y        (move_y),
		.growth        (growth),
		.rotation      (rotation),
		.contact_count (contact_count),
		.last          (last)
	);

endmodule
